// ----- design/assert_macros.svh -----
// Assertion helpers, compiled out with ASSERT_OFF.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, quiet during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/crsdp_pkg.sv -----
package crsdp_pkg;

    localparam int COLUMN_W          = 10;
    localparam int VALUE_W           = 32;
    localparam int FUNC_W            = 2;
    localparam int SUM_W             = 64;
    localparam int ROW_W             = 16;
    localparam int VECTOR_LENGTH_DEF = 1024;
    localparam int QUEUE_DEPTH       = 4;
    localparam int S_TDATA_W         = 48;
    localparam int M_TDATA_W         = 80;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_TERM  = 2'd1,
        FUNC_CLOSE = 2'd2
    } t_func;

    // one multiply-accumulate step for the back end
    typedef struct packed {
        logic                      emit;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] x;
    } t_op;

    typedef struct packed {
        logic f_valid;
        logic push;
    } t_front_status;

endpackage

// ----- design/crsdp_front.sv -----
module crsdp_front #(
    parameter int VECTOR_LENGTH = crsdp_pkg::VECTOR_LENGTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [crsdp_pkg::FUNC_W-1:0]       i_func,
    input  logic [crsdp_pkg::COLUMN_W-1:0]     i_column,
    input  logic signed [crsdp_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_last,
    input  logic                               i_full,
    output crsdp_pkg::t_front_status           o_status,
    output crsdp_pkg::t_op                     o_op
);

    localparam int COL_SPAN = 1 << crsdp_pkg::COLUMN_W;
    localparam int DEPTH    = (VECTOR_LENGTH < COL_SPAN) ? VECTOR_LENGTH : COL_SPAN;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [crsdp_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic signed [crsdp_pkg::VALUE_W-1:0] r_rdata;

    logic                                 r_f_valid, n_f_valid;
    logic                                 r_f_emit;
    logic                                 r_f_use_x;
    logic signed [crsdp_pkg::VALUE_W-1:0] r_f_value;

    logic          w_accept;
    logic          w_push;
    logic          w_in_range;
    logic          w_is_term;
    logic          w_is_close;
    logic [AW-1:0] w_addr;

    assign w_in_range = (32'(i_column) < 32'(VECTOR_LENGTH));
    assign w_addr     = i_column[AW-1:0];
    assign w_is_term  = (i_func == crsdp_pkg::FUNC_TERM);
    assign w_is_close = (i_func == crsdp_pkg::FUNC_CLOSE);

    assign o_ready  = !r_f_valid || !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_push   = r_f_valid && !i_full;

    // vector store: a write on each load, and a registered read on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_func == crsdp_pkg::FUNC_LOAD) && w_in_range) begin
            r_mem[w_addr] <= i_value;
        end
        if (w_accept) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_comb begin
        n_f_valid = r_f_valid;
        if (w_accept) begin
            case (crsdp_pkg::t_func'(i_func))
                crsdp_pkg::FUNC_TERM:  n_f_valid = 1'b1;
                crsdp_pkg::FUNC_CLOSE: n_f_valid = 1'b1;
                default:               n_f_valid = 1'b0;
            endcase
        end else if (w_push) begin
            n_f_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= n_f_valid;
        end
    end

    // a close carries a zero term so the back end treats it as a term
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f_emit  <= w_is_close || (w_is_term && i_last);
            r_f_use_x <= w_is_term && w_in_range;
            r_f_value <= w_is_term ? i_value : '0;
        end
    end

    assign o_op.emit  = r_f_emit;
    assign o_op.value = r_f_value;
    assign o_op.x     = r_f_use_x ? r_rdata : '0;

    assign o_status.f_valid = r_f_valid;
    assign o_status.push    = w_push;

endmodule

// ----- design/crsdp_queue.sv -----
module crsdp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  crsdp_pkg::t_op i_op,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output crsdp_pkg::t_op o_op
);

    localparam int PTR_W = $clog2(crsdp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    crsdp_pkg::t_op r_slot [crsdp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(crsdp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_op    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/crsdp_back.sv -----
module crsdp_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  crsdp_pkg::t_op                       i_op,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [crsdp_pkg::SUM_W-1:0]   o_row_sum,
    output logic [crsdp_pkg::ROW_W-1:0]          o_row_number,
    output logic                                 o_saturated
);

    localparam logic signed [crsdp_pkg::SUM_W-1:0] SUM_MAX =
        {1'b0, {(crsdp_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [crsdp_pkg::SUM_W-1:0] SUM_MIN =
        {1'b1, {(crsdp_pkg::SUM_W-1){1'b0}}};

    // multiply stage
    logic                                 r_m_valid;
    logic                                 r_m_emit;
    logic signed [crsdp_pkg::SUM_W-1:0]   r_m_prod;
    logic signed [crsdp_pkg::SUM_W-1:0]   w_prod;

    // accumulate state
    logic signed [crsdp_pkg::SUM_W-1:0]   r_sum;
    logic                                 r_ovf;
    logic [crsdp_pkg::ROW_W-1:0]          r_row;

    // output register
    logic                                 r_o_valid;
    logic signed [crsdp_pkg::SUM_W-1:0]   r_o_sum;
    logic [crsdp_pkg::ROW_W-1:0]          r_o_row;
    logic                                 r_o_sat;

    logic                                 w_out_free;
    logic                                 w_a_fire;
    logic                                 w_m_load;
    logic [crsdp_pkg::SUM_W:0]            w_wide;
    logic                                 w_ovf;
    logic signed [crsdp_pkg::SUM_W-1:0]   w_sat_sum;

    assign w_out_free = !r_o_valid || i_ready;
    assign w_a_fire   = r_m_valid && (!r_m_emit || w_out_free);
    assign o_ready    = !r_m_valid || w_a_fire;
    assign w_m_load   = i_valid && o_ready;

    assign w_prod = i_op.value * i_op.x;

    // saturating add: overflow when the two top bits of the wide sum differ
    assign w_wide    = {r_sum[crsdp_pkg::SUM_W-1], r_sum}
                     + {r_m_prod[crsdp_pkg::SUM_W-1], r_m_prod};
    assign w_ovf     = w_wide[crsdp_pkg::SUM_W] != w_wide[crsdp_pkg::SUM_W-1];
    assign w_sat_sum = !w_ovf ? w_wide[crsdp_pkg::SUM_W-1:0]
                     : (w_wide[crsdp_pkg::SUM_W] ? SUM_MIN : SUM_MAX);

    always_ff @(posedge i_clk) begin
        if (w_m_load) begin
            r_m_emit <= i_op.emit;
            r_m_prod <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_sum     <= '0;
            r_ovf     <= 1'b0;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_m_load) begin
                r_m_valid <= 1'b1;
            end else if (w_a_fire) begin
                r_m_valid <= 1'b0;
            end

            if (w_a_fire && r_m_emit) begin
                r_sum     <= '0;
                r_ovf     <= 1'b0;
                r_row     <= r_row + 1'b1;
                r_o_valid <= 1'b1;
            end else begin
                if (w_a_fire) begin
                    r_sum <= w_sat_sum;
                    r_ovf <= r_ovf || w_ovf;
                end
                if (i_ready) begin
                    r_o_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_fire && r_m_emit) begin
            r_o_sum <= w_sat_sum;
            r_o_row <= r_row;
            r_o_sat <= r_ovf || w_ovf;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_row_sum    = r_o_sum;
    assign o_row_number = r_o_row;
    assign o_saturated  = r_o_sat;

endmodule

// ----- design/csr_sparse_row_dot_product.sv -----
// Path: a row-closing transaction passes the front register, queue, multiply and output registers.
// Throughput: one transaction per cycle while the queue is not full; one 32x32 multiplier and one 64-bit
//   saturating accumulate register each take one term per cycle while the output is not stalled.
// Reset: i_rst_n is synchronous, active low; it clears the running sum, row counter,
//   saturation flag and all valid state. The vector store is not cleared by reset.
`include "assert_macros.svh"

// CSR sparse row dot product.
// Front end: decodes the transaction kind, owns the vector store (a load writes; every accept
// does a registered read), and turns each term or row close into a multiply op.
// A four-entry queue decouples it from the back end, which multiplies (registered),
// accumulates with saturation and holds the finished row in an output register.
// A load followed by a term on the same column in the next cycle sees the new value:
// the write lands at the load's edge, the read happens at the term's edge.
module csr_sparse_row_dot_product #(
    parameter int VECTOR_LENGTH = crsdp_pkg::VECTOR_LENGTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [crsdp_pkg::S_TDATA_W-1:0]     i_s_tdata,   // column[9:0], value[41:10], zero
    input  logic [crsdp_pkg::FUNC_W-1:0]        i_s_tuser,   // func[1:0]
    input  logic                                i_s_tlast,   // end_of_row
    // master side
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [crsdp_pkg::M_TDATA_W-1:0]     o_m_tdata,   // row_sum[63:0], row_number[79:64]
    output logic [0:0]                          o_m_tuser    // saturated[0]
);

    localparam int VAL_LO = crsdp_pkg::COLUMN_W;
    localparam int VAL_HI = crsdp_pkg::COLUMN_W + crsdp_pkg::VALUE_W - 1;

    crsdp_pkg::t_front_status             w_front_status;
    crsdp_pkg::t_op                       w_front_op;
    crsdp_pkg::t_op                       w_queue_op;
    logic                                 w_q_full;
    logic                                 w_q_valid;
    logic                                 w_back_ready;
    logic signed [crsdp_pkg::SUM_W-1:0]   w_row_sum;
    logic [crsdp_pkg::ROW_W-1:0]          w_row_number;
    logic                                 w_saturated;
    logic                                 w_s_accept;

    assign w_s_accept = i_s_tvalid && o_s_tready;

    crsdp_front #(
        .VECTOR_LENGTH(VECTOR_LENGTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_func   (i_s_tuser),
        .i_column (i_s_tdata[crsdp_pkg::COLUMN_W-1:0]),
        .i_value  ($signed(i_s_tdata[VAL_HI:VAL_LO])),
        .i_last   (i_s_tlast),
        .i_full   (w_q_full),
        .o_status (w_front_status),
        .o_op     (w_front_op)
    );

    crsdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_status.push),
        .i_op    (w_front_op),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_back_ready),
        .o_op    (w_queue_op)
    );

    crsdp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .o_ready      (w_back_ready),
        .i_op         (w_queue_op),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_row_sum    (w_row_sum),
        .o_row_number (w_row_number),
        .o_saturated  (w_saturated)
    );

    assign o_m_tdata = {w_row_number, w_row_sum};
    assign o_m_tuser = w_saturated;

    // input back-pressure only ever comes from a full queue
    `ASSERT_IMPLIES(a_stall_from_queue, i_clk, i_rst_n, !o_s_tready, w_q_full)
    // a vector load never reaches the back end
    `ASSERT_NEXT(a_load_no_push, i_clk, i_rst_n,
        w_s_accept && (i_s_tuser == crsdp_pkg::FUNC_LOAD), !w_front_status.push)
    // a row close is always staged for the queue on the next cycle
    `ASSERT_NEXT(a_close_staged, i_clk, i_rst_n,
        w_s_accept && (i_s_tuser == crsdp_pkg::FUNC_CLOSE), w_front_status.f_valid)

endmodule
